### src/imhd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imhd_pkg
// Shared types and codes for the indexed min-heap decrease-key unit.
// ----------------------------------------------------------------------------
package imhd_pkg;

    // Request opcodes.
    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_UPD   = 2'd2;
    localparam logic [1:0] OP_QUERY = 2'd3;

    // Status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_ABSENT   = 2'd2;
    localparam logic [1:0] ST_REJECTED = 2'd3;

    // Number of distinct node ids that the 8-bit node field can name.
    localparam int ID_SPACE = 256;

    // One heap entry as stored in the slot memory.
    typedef struct packed {
        logic [7:0]  node;
        logic [8:0]  src;
        logic [31:0] key;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Result of one request, handed from the sequencer to the output register.
    typedef struct packed {
        logic [1:0]  status;
        t_entry      top;
        logic        present;
        logic        lowered;
        logic [8:0]  count;
    } t_result;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_UPD_MAP,
        S_UPD_RD,
        S_POP_TOP,
        S_POP_LAST,
        S_UP_CHK,
        S_UP_CMP,
        S_DN_CHK,
        S_DN_L,
        S_DN_R,
        S_DN_CMP,
        S_DONE
    } t_state;

endpackage

### src/imhd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imhd_ram
// Simple dual-port synchronous memory: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module imhd_ram #(
    parameter int DEPTH  = 256,
    parameter int WIDTH  = 8,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

### src/imhd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imhd_ctrl
// Request sequencer: decodes a request, holds the presence flags and heap
// size, and walks the heap one level at a time through the slot memory.
// ----------------------------------------------------------------------------
module imhd_ctrl import imhd_pkg::*; #(
    parameter int NODE_COUNT = 256,
    parameter int AW         = $clog2(NODE_COUNT),
    parameter int SW         = $clog2(NODE_COUNT + 1)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    // Request beat.
    input  logic           i_valid,
    output logic           o_busy,
    input  logic [1:0]     i_opcode,
    input  logic [7:0]     i_node_id,
    input  logic [8:0]     i_source_id,
    input  logic [31:0]    i_key_distance,
    // Result hand-off.
    output logic           o_res_valid,
    input  logic           i_res_take,
    output t_result        o_res,
    // Slot memory.
    output logic           o_heap_we,
    output logic [AW-1:0]  o_heap_waddr,
    output t_entry         o_heap_wdata,
    output logic           o_heap_re,
    output logic [AW-1:0]  o_heap_raddr,
    input  t_entry         i_heap_rdata,
    // Position map memory.
    output logic           o_map_we,
    output logic [7:0]     o_map_waddr,
    output logic [AW-1:0]  o_map_wdata,
    output logic           o_map_re,
    output logic [7:0]     o_map_raddr,
    input  logic [AW-1:0]  i_map_rdata
);

    localparam int CW = AW + 2;

    t_state             r_state, n_state;
    logic [7:0]         r_node, n_node;
    logic [8:0]         r_src, n_src;
    logic [31:0]        r_key, n_key;
    logic [SW-1:0]      r_size, n_size;
    logic [AW-1:0]      r_pos, n_pos;
    t_entry             r_ent, n_ent;
    t_entry             r_left, n_left;
    t_entry             r_right, n_right;
    logic               r_has_r, n_has_r;
    t_entry             r_top, n_top;
    logic [1:0]         r_status, n_status;
    logic               r_present, n_present;
    logic               r_lowered, n_lowered;
    logic [ID_SPACE-1:0] r_here, n_here;

    logic               accept;
    logic               in_range;
    logic               heap_full;
    logic [AW-1:0]      parent_idx;
    logic [CW-1:0]      left_idx;
    logic [CW-1:0]      right_idx;
    logic [CW-1:0]      size_ext;
    logic               left_in;
    logic               right_in;
    logic [SW-1:0]      size_dec;
    logic               up_less;
    logic               pick_l;
    logic [31:0]        best_key;
    logic               pick_r;

    // Handshake and decode helpers.
    assign accept     = i_valid && (r_state == S_IDLE);
    assign o_busy     = (r_state != S_IDLE);
    assign in_range   = (32'(i_node_id) < 32'(NODE_COUNT));
    assign heap_full  = (32'(r_size) >= 32'(NODE_COUNT));
    assign size_dec   = r_size - SW'(1);

    // Index arithmetic for the current level.
    assign parent_idx = (r_pos - AW'(1)) >> 1;
    assign left_idx   = {1'b0, r_pos, 1'b1};
    assign right_idx  = left_idx + CW'(1);
    assign size_ext   = CW'(r_size);
    assign left_in    = (left_idx < size_ext);
    assign right_in   = (right_idx < size_ext);

    // Key comparisons.
    assign up_less    = (r_ent.key < i_heap_rdata.key);
    assign pick_l     = !(r_ent.key < r_left.key);
    assign best_key   = pick_l ? r_left.key : r_ent.key;
    assign pick_r     = r_has_r && (r_right.key < best_key);

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_opcode)
                        OP_PUSH: begin
                            if (!in_range || r_here[i_node_id] || heap_full) begin
                                n_state = S_DONE;
                            end else begin
                                n_state = S_UP_CHK;
                            end
                        end
                        OP_POP: begin
                            n_state = (r_size == '0) ? S_DONE : S_POP_TOP;
                        end
                        OP_UPD: begin
                            if (!in_range || !r_here[i_node_id]) begin
                                n_state = S_DONE;
                            end else begin
                                n_state = S_UPD_MAP;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_UPD_MAP:  n_state = S_UPD_RD;
            S_UPD_RD:   n_state = (r_key < i_heap_rdata.key) ? S_UP_CHK : S_DONE;
            S_POP_TOP:  n_state = (size_dec == '0) ? S_DONE : S_POP_LAST;
            S_POP_LAST: n_state = S_DN_CHK;
            S_UP_CHK:   n_state = (r_pos == '0) ? S_DONE : S_UP_CMP;
            S_UP_CMP:   n_state = up_less ? S_UP_CHK : S_DONE;
            S_DN_CHK:   n_state = left_in ? S_DN_L : S_DONE;
            S_DN_L:     n_state = right_in ? S_DN_R : S_DN_CMP;
            S_DN_R:     n_state = S_DN_CMP;
            S_DN_CMP:   n_state = (pick_r || pick_l) ? S_DN_CHK : S_DONE;
            S_DONE:     n_state = i_res_take ? S_IDLE : S_DONE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Datapath and memory controls.
    always_comb begin
        n_node    = r_node;
        n_src     = r_src;
        n_key     = r_key;
        n_size    = r_size;
        n_pos     = r_pos;
        n_ent     = r_ent;
        n_left    = r_left;
        n_right   = r_right;
        n_has_r   = r_has_r;
        n_top     = r_top;
        n_status  = r_status;
        n_present = r_present;
        n_lowered = r_lowered;
        n_here    = r_here;

        o_heap_we    = 1'b0;
        o_heap_waddr = r_pos;
        o_heap_wdata = r_ent;
        o_heap_re    = 1'b0;
        o_heap_raddr = '0;
        o_map_we     = 1'b0;
        o_map_waddr  = r_ent.node;
        o_map_wdata  = r_pos;
        o_map_re     = 1'b0;
        o_map_raddr  = i_node_id;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_node    = i_node_id;
                    n_src     = i_source_id;
                    n_key     = i_key_distance;
                    n_top     = '0;
                    n_status  = ST_OK;
                    n_present = 1'b0;
                    n_lowered = 1'b0;
                    unique case (i_opcode)
                        OP_PUSH: begin
                            if (!in_range || r_here[i_node_id] || heap_full) begin
                                n_status = ST_REJECTED;
                            end else begin
                                n_here[i_node_id] = 1'b1;
                                n_size = r_size + SW'(1);
                                n_ent  = '{node: i_node_id, src: i_source_id,
                                           key: i_key_distance};
                                n_pos  = AW'(r_size);
                            end
                        end
                        OP_POP: begin
                            if (r_size == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                o_heap_re    = 1'b1;
                                o_heap_raddr = '0;
                            end
                        end
                        OP_UPD: begin
                            if (!in_range || !r_here[i_node_id]) begin
                                n_status = ST_ABSENT;
                            end else begin
                                o_map_re = 1'b1;
                            end
                        end
                        default: begin
                            n_present = in_range && r_here[i_node_id];
                        end
                    endcase
                end
            end
            // Slot of the node is known; fetch its entry.
            S_UPD_MAP: begin
                n_pos        = i_map_rdata;
                o_heap_re    = 1'b1;
                o_heap_raddr = i_map_rdata;
            end
            // Lower the key only when strictly smaller.
            S_UPD_RD: begin
                if (r_key < i_heap_rdata.key) begin
                    n_ent     = '{node: r_node, src: r_src, key: r_key};
                    n_lowered = 1'b1;
                end
            end
            // Root entry is out; fetch the last entry if any remain.
            S_POP_TOP: begin
                n_top                     = i_heap_rdata;
                n_here[i_heap_rdata.node] = 1'b0;
                n_size                    = size_dec;
                if (size_dec != '0) begin
                    o_heap_re    = 1'b1;
                    o_heap_raddr = AW'(size_dec);
                end
            end
            S_POP_LAST: begin
                n_ent = i_heap_rdata;
                n_pos = '0;
            end
            // Sift up: stop at the root, otherwise fetch the parent.
            S_UP_CHK: begin
                if (r_pos == '0) begin
                    o_heap_we = 1'b1;
                    o_map_we  = 1'b1;
                end else begin
                    o_heap_re    = 1'b1;
                    o_heap_raddr = parent_idx;
                end
            end
            // Move the parent down or settle the entry here.
            S_UP_CMP: begin
                o_heap_we = 1'b1;
                o_map_we  = 1'b1;
                if (up_less) begin
                    o_heap_wdata = i_heap_rdata;
                    o_map_waddr  = i_heap_rdata.node;
                    n_pos        = parent_idx;
                end
            end
            // Sift down: settle at a leaf, otherwise fetch the left child.
            S_DN_CHK: begin
                if (left_in) begin
                    o_heap_re    = 1'b1;
                    o_heap_raddr = left_idx[AW-1:0];
                end else begin
                    o_heap_we = 1'b1;
                    o_map_we  = 1'b1;
                end
            end
            S_DN_L: begin
                n_left  = i_heap_rdata;
                n_has_r = right_in;
                if (right_in) begin
                    o_heap_re    = 1'b1;
                    o_heap_raddr = right_idx[AW-1:0];
                end
            end
            S_DN_R: begin
                n_right = i_heap_rdata;
            end
            // Pull the smaller child up; the left child wins a tie with the entry.
            S_DN_CMP: begin
                o_heap_we = 1'b1;
                o_map_we  = 1'b1;
                if (pick_r) begin
                    o_heap_wdata = r_right;
                    o_map_waddr  = r_right.node;
                    n_pos        = right_idx[AW-1:0];
                end else if (pick_l) begin
                    o_heap_wdata = r_left;
                    o_map_waddr  = r_left.node;
                    n_pos        = left_idx[AW-1:0];
                end
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // Result toward the output register.
    assign o_res_valid   = (r_state == S_DONE);
    assign o_res.status  = r_status;
    assign o_res.top     = r_top;
    assign o_res.present = r_present;
    assign o_res.lowered = r_lowered;
    assign o_res.count   = 9'(r_size);

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_size  <= '0;
            r_here  <= '0;
        end else begin
            r_state <= n_state;
            r_size  <= n_size;
            r_here  <= n_here;
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        r_node    <= n_node;
        r_src     <= n_src;
        r_key     <= n_key;
        r_pos     <= n_pos;
        r_ent     <= n_ent;
        r_left    <= n_left;
        r_right   <= n_right;
        r_has_r   <= n_has_r;
        r_top     <= n_top;
        r_status  <= n_status;
        r_present <= n_present;
        r_lowered <= n_lowered;
    end

endmodule

### src/indexed_min_heap_decrease_key_unit.sv
`timescale 1ns / 1ps
// A query or rejected request goes straight to its result; a push first climbs
// the heap one level at a time, an update first reads its map and slot and then
// climbs like a push, and a pop descends the heap level by level. One request
// at a time: the next is accepted the cycle after a result moves out.
// Reset clears heap size and presence flags at once; no clearing pass.
// ----------------------------------------------------------------------------
// indexed_min_heap_decrease_key_unit
// Indexed binary min-heap with push, pop, decrease-key and membership query.
// ----------------------------------------------------------------------------
module indexed_min_heap_decrease_key_unit import imhd_pkg::*; #(
    parameter int NODE_COUNT = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_opcode,
    input  logic [7:0]         i_node_id,
    input  logic signed [8:0]  i_source_id,
    input  logic [31:0]        i_key_distance,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_status,
    output logic [7:0]         o_popped_node,
    output logic signed [8:0]  o_popped_source,
    output logic [31:0]        o_popped_distance,
    output logic               o_is_present,
    output logic               o_key_lowered,
    output logic [8:0]         o_entry_count
);

    localparam int AW = $clog2(NODE_COUNT);
    localparam int SW = $clog2(NODE_COUNT + 1);

    logic           res_valid;
    logic           res_take;
    t_result        res;
    logic           heap_we, heap_re;
    logic [AW-1:0]  heap_waddr, heap_raddr;
    t_entry         heap_wdata, heap_rdata;
    logic [ENTRY_W-1:0] heap_rbits;
    logic           map_we, map_re;
    logic [7:0]     map_waddr, map_raddr;
    logic [AW-1:0]  map_wdata, map_rdata;

    assign heap_rdata = t_entry'(heap_rbits);

    imhd_ctrl #(
        .NODE_COUNT (NODE_COUNT),
        .AW         (AW),
        .SW         (SW)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_busy         (o_stall),
        .i_opcode       (i_opcode),
        .i_node_id      (i_node_id),
        .i_source_id    (i_source_id),
        .i_key_distance (i_key_distance),
        .o_res_valid    (res_valid),
        .i_res_take     (res_take),
        .o_res          (res),
        .o_heap_we      (heap_we),
        .o_heap_waddr   (heap_waddr),
        .o_heap_wdata   (heap_wdata),
        .o_heap_re      (heap_re),
        .o_heap_raddr   (heap_raddr),
        .i_heap_rdata   (heap_rdata),
        .o_map_we       (map_we),
        .o_map_waddr    (map_waddr),
        .o_map_wdata    (map_wdata),
        .o_map_re       (map_re),
        .o_map_raddr    (map_raddr),
        .i_map_rdata    (map_rdata)
    );

    // Heap slots: one entry per slot.
    imhd_ram #(
        .DEPTH (NODE_COUNT),
        .WIDTH (ENTRY_W)
    ) u_heap_ram (
        .i_clk   (i_clk),
        .i_we    (heap_we),
        .i_waddr (heap_waddr),
        .i_wdata (heap_wdata),
        .i_re    (heap_re),
        .i_raddr (heap_raddr),
        .o_rdata (heap_rbits)
    );

    // Position map: slot of each node id.
    imhd_ram #(
        .DEPTH (ID_SPACE),
        .WIDTH (AW)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_re    (map_re),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

    // Output register: takes a result whenever the last beat is gone.
    assign res_take = !o_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (res_valid && res_take) begin
            o_valid <= 1'b1;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_take) begin
            o_status          <= res.status;
            o_popped_node     <= res.top.node;
            o_popped_source   <= res.top.src;
            o_popped_distance <= res.top.key;
            o_is_present      <= res.present;
            o_key_lowered     <= res.lowered;
            o_entry_count     <= res.count;
        end
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random heap requests into the indexed min-heap unit and checks every
// result against a behavioral heap kept in the testbench.
// ----------------------------------------------------------------------------
module tb_top;
    import imhd_pkg::*;

    localparam int RAND_ITEMS = 1130;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  node;
        logic [8:0]  src;
        logic [31:0] key;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  pnode;
        logic [8:0]  psrc;
        logic [31:0] pdist;
        logic        present;
        logic        lowered;
        logic [8:0]  count;
    } t_answer;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [1:0] i_opcode = '0;
    logic [7:0] i_node_id = '0;
    logic signed [8:0] i_source_id = '0;
    logic [31:0] i_key_distance = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [1:0] o_status;
    logic [7:0] o_popped_node;
    logic signed [8:0] o_popped_source;
    logic [31:0] o_popped_distance;
    logic o_is_present;
    logic o_key_lowered;
    logic [8:0] o_entry_count;

    indexed_min_heap_decrease_key_unit i_dut (.*);

    always #2 i_clk = ~i_clk;

    // Behavioral heap state.
    t_entry heap_mem [ID_SPACE];
    int     node_slot [ID_SPACE];
    bit     node_held [ID_SPACE];
    int     heap_count = 0;

    t_req    pending_reqs [$];
    t_answer expected_answers [$];
    int  errors = 0;
    bit  quiet_mode = 1'b0;
    int  hold_off_cycles = 0;
    bit  sender_paused = 1'b0;

    task automatic report(input string what, input logic [31:0] got,
                          input logic [31:0] want);
        $display("ERROR %0t: %s got %0h expected %0h", $realtime, what, got, want);
        errors++;
    endtask

    // Append one request to the tail of the pending queue.
    function automatic void add_req(input t_req q);
        pending_reqs.insert(pending_reqs.size(), q);
    endfunction

    function automatic void swap_slots(input int a, input int b);
        t_entry t;
        t = heap_mem[a];
        heap_mem[a] = heap_mem[b];
        heap_mem[b] = t;
        node_slot[heap_mem[a].node] = a;
        node_slot[heap_mem[b].node] = b;
    endfunction

    function automatic void climb(input int pos);
        int up;
        while (pos > 0) begin
            up = (pos - 1) / 2;
            if (heap_mem[pos].key < heap_mem[up].key) begin
                swap_slots(pos, up);
                pos = up;
            end else begin
                break;
            end
        end
    endfunction

    // A tie with the left child still moves the entry down.
    function automatic void descend(input int pos);
        int l, r, best;
        forever begin
            l = 2 * pos + 1;
            r = l + 1;
            if (l >= heap_count) break;
            best = (heap_mem[pos].key < heap_mem[l].key) ? pos : l;
            if (r < heap_count && heap_mem[r].key < heap_mem[best].key) best = r;
            if (best == pos) break;
            swap_slots(best, pos);
            pos = best;
        end
    endfunction

    function automatic t_answer heap_apply(input t_req q);
        t_answer a;
        t_entry top;
        int pos;
        a = '0;
        case (q.op)
            OP_PUSH: begin
                if (node_held[q.node] || heap_count >= ID_SPACE) begin
                    a.status = ST_REJECTED;
                end else begin
                    pos = heap_count;
                    heap_mem[pos] = '{node: q.node, src: q.src, key: q.key};
                    node_slot[q.node] = pos;
                    node_held[q.node] = 1'b1;
                    heap_count++;
                    climb(pos);
                end
            end
            OP_POP: begin
                if (heap_count == 0) begin
                    a.status = ST_EMPTY;
                end else begin
                    top = heap_mem[0];
                    node_held[top.node] = 1'b0;
                    heap_count--;
                    if (heap_count > 0) begin
                        heap_mem[0] = heap_mem[heap_count];
                        node_slot[heap_mem[0].node] = 0;
                        descend(0);
                    end
                    a.pnode = top.node;
                    a.psrc = top.src;
                    a.pdist = top.key;
                end
            end
            OP_UPD: begin
                if (!node_held[q.node]) begin
                    a.status = ST_ABSENT;
                end else begin
                    pos = node_slot[q.node];
                    if (q.key < heap_mem[pos].key) begin
                        heap_mem[pos].key = q.key;
                        heap_mem[pos].src = q.src;
                        climb(pos);
                        a.lowered = 1'b1;
                    end
                end
            end
            default: begin
                a.present = node_held[q.node];
            end
        endcase
        a.count = heap_count[8:0];
        return a;
    endfunction

    function automatic logic [31:0] rand_key();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_req make_req(input logic [1:0] op, input int node_max);
        t_req q;
        q.op = op;
        q.node = $urandom_range(0, node_max);
        q.src = ($urandom_range(0, 7) == 0) ? 9'h1FF : 9'($urandom);
        q.key = rand_key();
        return q;
    endfunction

    // Driver: present the head of the queue, idling in random bursts.
    int send_idle = 0;
    always @(posedge i_clk) begin
        t_req q;
        if (i_rst_n) begin
            if (!i_valid || !o_stall) begin
                if (i_valid) pending_reqs.pop_front();
                if (send_idle > 0) begin
                    send_idle <= send_idle - 1;
                    i_valid <= 1'b0;
                end else if (!quiet_mode && $urandom_range(0, 9) == 0) begin
                    send_idle <= $urandom_range(0, 5);
                    i_valid <= 1'b0;
                end else if (pending_reqs.size() > 0 && !sender_paused) begin
                    q = pending_reqs[0];
                    i_valid <= 1'b1;
                    i_opcode <= q.op;
                    i_node_id <= q.node;
                    i_source_id <= q.src;
                    i_key_distance <= q.key;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Predict each accepted beat at acceptance.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            expected_answers.insert(expected_answers.size(),
                heap_apply('{op: i_opcode, node: i_node_id,
                             src: i_source_id, key: i_key_distance}));
        end
    end

    // Receiver stall: random bursts or a long hold-off.
    int recv_idle = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (hold_off_cycles > 0) begin
                hold_off_cycles <= hold_off_cycles - 1;
                i_stall <= 1'b1;
            end else if (recv_idle > 0) begin
                recv_idle <= recv_idle - 1;
                i_stall <= 1'b1;
            end else if (!quiet_mode && $urandom_range(0, 7) == 0) begin
                recv_idle <= $urandom_range(0, 5);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Monitor: compare each result beat with the oldest expectation.
    always @(posedge i_clk) begin
        t_answer w;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_answers.size() == 0) begin
                report("unexpected result beat", 0, 0);
            end else begin
                w = expected_answers.pop_front();
                if (o_status !== w.status) report("status", o_status, w.status);
                if (o_popped_node !== w.pnode) report("popped_node", o_popped_node, w.pnode);
                if (o_popped_source !== w.psrc)
                    report("popped_source", o_popped_source, w.psrc);
                if (o_popped_distance !== w.pdist)
                    report("popped_distance", o_popped_distance, w.pdist);
                if (o_is_present !== w.present)
                    report("is_present", o_is_present, w.present);
                if (o_key_lowered !== w.lowered)
                    report("key_lowered", o_key_lowered, w.lowered);
                if (o_entry_count !== w.count)
                    report("entry_count", o_entry_count, w.count);
            end
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || expected_answers.size() != 0 || i_valid)
            @(posedge i_clk);
    endtask

    // Stimulus and end of run.
    initial begin
        t_req q;
        int r, sel;
        for (int i = 0; i < ID_SPACE; i++) node_held[i] = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty pop, absent update and query, field extremes, ties.
        add_req('{OP_POP, 8'd0, 9'd0, 32'd0});
        add_req('{OP_UPD, 8'd5, 9'd1, 32'd1});
        add_req('{OP_QUERY, 8'd255, 9'd0, 32'd0});
        add_req('{OP_PUSH, 8'd255, 9'h1FF, 32'hFFFF_FFFF});
        add_req('{OP_PUSH, 8'd255, 9'd3, 32'd3});
        add_req('{OP_PUSH, 8'd0, 9'h0FF, 32'd7});
        add_req('{OP_PUSH, 8'd1, 9'h100, 32'd7});
        add_req('{OP_PUSH, 8'd2, 9'd0, 32'd7});
        add_req('{OP_PUSH, 8'd3, 9'd9, 32'd0});
        add_req('{OP_QUERY, 8'd255, 9'd0, 32'd0});
        add_req('{OP_UPD, 8'd255, 9'd4, 32'hFFFF_FFFF});
        add_req('{OP_UPD, 8'd255, 9'd4, 32'd7});
        add_req('{OP_UPD, 8'd2, 9'h1FF, 32'd6});
        for (int i = 0; i < 6; i++) add_req('{OP_POP, 8'd0, 9'd0, 32'd0});
        wait_drained();

        // Fill the heap completely while the receiver holds off.
        hold_off_cycles = 400;
        for (int i = 0; i < ID_SPACE; i++)
            add_req('{OP_PUSH, 8'(i), 9'($urandom), rand_key()});
        add_req('{OP_PUSH, 8'd17, 9'd0, 32'd0});
        for (int i = 0; i < 40; i++) add_req(make_req(OP_UPD, 255));
        for (int i = 0; i < ID_SPACE + 1; i++)
            add_req('{OP_POP, 8'd0, 9'd0, 32'd0});
        wait_drained();

        // Random mix: mostly small node ids so requests hit held entries.
        for (int i = 0; i < RAND_ITEMS; i++) begin
            if (i == RAND_ITEMS * 4 / 5) quiet_mode = 1'b1;
            r = $urandom_range(0, 99);
            sel = (r < 35) ? OP_PUSH : (r < 60) ? OP_POP : (r < 85) ? OP_UPD : OP_QUERY;
            q = make_req(2'(sel), ($urandom_range(0, 9) == 0) ? 255 : 31);
            add_req(q);
            if (i == RAND_ITEMS / 2) begin
                // Sender pauses until everything has been answered.
                sender_paused = 1'b1;
                while (expected_answers.size() != 0 || i_valid) @(posedge i_clk);
                sender_paused = 1'b0;
            end
            if (pending_reqs.size() > 32) wait (pending_reqs.size() < 8);
        end
        wait_drained();
        repeat (50) @(posedge i_clk);
        if (errors == 0 && expected_answers.size() == 0) begin
            $display("indexed_min_heap_decrease_key_unit: match");
        end else begin
            $display("indexed_min_heap_decrease_key_unit: mismatch");
        end
        $finish;
    end

    // Run limit, far beyond the slowest correct run.
    initial begin
        #2000000;
        $display("indexed_min_heap_decrease_key_unit: mismatch");
        $finish;
    end

endmodule
